// ===== hdl/bbc_pkg.sv =====
// Package for the bracket balance checker: bracket kind codes, character
// constants, result struct and the character classification functions.
// No dependencies.
package bbc_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAREN = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY = 2'd2;
  localparam kind_t KIND_ANGLE = 2'd3;

  localparam logic [7:0] CH_OPEN_PAREN = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY = 8'h7B;
  localparam logic [7:0] CH_OPEN_ANGLE = 8'h3C;
  localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;
  localparam logic [7:0] CH_CLOSE_ANGLE = 8'h3E;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } bracket_t;

  typedef struct packed {
    logic failed;
    logic done;
    logic balanced;
  } result_t;

  function automatic bracket_t opener_kind(input logic [7:0] ch);
    bracket_t b;
    b.hit = 1'b1;
    case (ch)
      CH_OPEN_PAREN: b.kind = KIND_PAREN;
      CH_OPEN_SQUARE: b.kind = KIND_SQUARE;
      CH_OPEN_CURLY: b.kind = KIND_CURLY;
      CH_OPEN_ANGLE: b.kind = KIND_ANGLE;
      default: begin
        b.hit = 1'b0;
        b.kind = KIND_PAREN;
      end
    endcase
    return b;
  endfunction

  function automatic bracket_t closer_kind(input logic [7:0] ch);
    bracket_t b;
    b.hit = 1'b1;
    case (ch)
      CH_CLOSE_PAREN: b.kind = KIND_PAREN;
      CH_CLOSE_SQUARE: b.kind = KIND_SQUARE;
      CH_CLOSE_CURLY: b.kind = KIND_CURLY;
      CH_CLOSE_ANGLE: b.kind = KIND_ANGLE;
      default: begin
        b.hit = 1'b0;
        b.kind = KIND_PAREN;
      end
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/bracket_balance_checker_top.sv =====
// Bracket balance checker: one character per item, one result per item.
// Results are registered in a two-entry output buffer. Throughput: one item per
// cycle while that buffer has room; the stack top is read from RAM each cycle at
// the new count, with the just-pushed kind forwarded past the read latency.
// Reset: synchronous active-low rst_n clears count, failure and '>' history;
// stack RAM contents are left as they are, since only pushed entries are read.
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_failed_so_far,
  output logic       out_string_done,
  output logic       out_balanced
);
  import bbc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          fail_r, fail_nxt;
  logic          prev_gt_r, prev_gt_nxt;
  logic          fwd_r, fwd_nxt;
  kind_t         fwd_kind_r;

  logic          accept;
  logic          can_push;
  logic          is_gt;
  bracket_t      ok, ck;
  kind_t         top_kind;
  kind_t         rd_data;
  logic          do_push, do_pop, fail_set;
  logic          fail_after;
  logic [CW-1:0] cnt_after;
  logic [CW-1:0] rd_cnt;
  logic [AW-1:0] wr_addr, rd_addr;
  result_t       res, out_res;

  assign accept = in_valid && in_ready;
  assign in_ready = can_push;

  assign is_gt = (in_char_in == CH_CLOSE_ANGLE);
  assign ok = opener_kind(in_char_in);
  assign ck = closer_kind(in_char_in);

  // The entry pushed in the previous cycle is not yet visible at the RAM output.
  assign top_kind = fwd_r ? fwd_kind_r : rd_data;

  always_comb begin
    do_push = 1'b0;
    do_pop = 1'b0;
    fail_set = 1'b0;
    if (!fail_r) begin
      if (is_gt && prev_gt_r) begin
        fail_set = 1'b1;
      end else if (ok.hit) begin
        do_push = (cnt_r < CW'(STACK_DEPTH));
      end else if (ck.hit) begin
        if (cnt_r != '0 && top_kind == ck.kind) begin
          do_pop = 1'b1;
        end else begin
          fail_set = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cnt_after = cnt_r;
    if (do_push) begin
      cnt_after = cnt_r + 1'b1;
    end else if (do_pop) begin
      cnt_after = cnt_r - 1'b1;
    end
  end

  assign fail_after = fail_r || fail_set;
  assign res.failed = fail_after;
  assign res.done = in_last_char;
  assign res.balanced = in_last_char && !fail_after && (cnt_after == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    fail_nxt = fail_r;
    prev_gt_nxt = prev_gt_r;
    if (accept) begin
      if (in_last_char) begin
        cnt_nxt = '0;
        fail_nxt = 1'b0;
        prev_gt_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_after;
        fail_nxt = fail_after;
        prev_gt_nxt = is_gt;
      end
    end
  end

  assign wr_addr = cnt_r[AW-1:0];
  assign rd_cnt = cnt_nxt - 1'b1;
  assign rd_addr = rd_cnt[AW-1:0];
  assign fwd_nxt = accept && do_push && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fail_r <= 1'b0;
      prev_gt_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      fail_r <= fail_nxt;
      prev_gt_r <= prev_gt_nxt;
      fwd_r <= fwd_nxt;
    end
    fwd_kind_r <= ok.kind;
  end

  bbc_ram #(
    .WIDTH($bits(kind_t)),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (accept && do_push),
    .wr_addr(wr_addr),
    .wr_data(ok.kind),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bbc_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(res),
    .can_push (can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_res)
  );

  assign out_failed_so_far = out_res.failed;
  assign out_string_done = out_res.done;
  assign out_balanced = out_res.balanced;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_char |=> cnt_r == '0 && !fail_r && !prev_gt_r)
    else $error("state not cleared after final item");
  a_frozen_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |-> !do_push && !do_pop) else $error("stack moved after failure");
  a_balanced_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_balanced |-> out_string_done && !out_failed_so_far)
    else $error("balanced flag on a non-final or failed result");

endmodule

// ===== hdl/bbc_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bbc_out_buf.sv =====
// Two-entry result buffer (output register plus skid register) that lets the
// checker take a new item while a result waits. Depends on bbc_pkg.
module bbc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bbc_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output bbc_pkg::result_t out_data
);
  import bbc_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_v_r && out_ready;
  assign can_push = !skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt = main_r;
    skid_nxt = skid_r;
    if (pop && skid_v_r) begin
      main_nxt = skid_r;
      skid_v_nxt = push;
      skid_nxt = push_data;
    end else if (pop) begin
      main_v_nxt = push;
      main_nxt = push_data;
    end else if (push) begin
      if (!main_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data = main_r;

  // The skid register only fills behind an occupied output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r) else $error("skid entry without output entry");
  // A stalled result holds its value.
  a_main_holds: assert property (@(posedge clk) disable iff (!rst_n)
    main_v_r && !out_ready |=> main_v_r && $stable(main_r))
    else $error("stalled result changed");
  // No item is taken when both entries are full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push) else $error("push into full result buffer");

endmodule

// ===== test/tb_bracket_balance_checker_top.sv =====
// Testbench for bracket_balance_checker_top: directed and random character strings,
// with each result checked against a bracket-nesting predictor.
// Depends on bbc_pkg and bracket_balance_checker_top.
module tb_bracket_balance_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int DEPTH = 128;
  localparam int ITEM_TARGET = 1900;

  typedef logic [7:0] char_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_in;
  logic       in_last_char;
  logic       out_valid;
  logic       out_ready;
  logic       out_failed_so_far;
  logic       out_string_done;
  logic       out_balanced;

  bracket_balance_checker_top #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_in(in_char_in),
    .in_last_char(in_last_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_failed_so_far(out_failed_so_far),
    .out_string_done(out_string_done),
    .out_balanced(out_balanced)
  );

  // Predictor state for the string in progress.
  kind_t       nest_stack[DEPTH];
  int unsigned nest_depth = 0;
  logic        string_failed = 1'b0;
  logic        prev_gt = 1'b0;

  result_t expected_results[$];
  char_t   draft[$];
  int      items_sent = 0;
  int      mismatches = 0;
  logic    send_fast = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic is_opener(char_t ch);
    return ch == CH_OPEN_PAREN || ch == CH_OPEN_SQUARE || ch == CH_OPEN_CURLY ||
           ch == CH_OPEN_ANGLE;
  endfunction

  function automatic logic is_closer(char_t ch);
    return ch == CH_CLOSE_PAREN || ch == CH_CLOSE_SQUARE || ch == CH_CLOSE_CURLY ||
           ch == CH_CLOSE_ANGLE;
  endfunction

  function automatic kind_t kind_of(char_t ch);
    case (ch)
      CH_OPEN_SQUARE, CH_CLOSE_SQUARE: return KIND_SQUARE;
      CH_OPEN_CURLY, CH_CLOSE_CURLY: return KIND_CURLY;
      CH_OPEN_ANGLE, CH_CLOSE_ANGLE: return KIND_ANGLE;
      default: return KIND_PAREN;
    endcase
  endfunction

  function automatic char_t opener_of(kind_t k);
    case (k)
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY: return CH_OPEN_CURLY;
      KIND_ANGLE: return CH_OPEN_ANGLE;
      default: return CH_OPEN_PAREN;
    endcase
  endfunction

  function automatic char_t closer_of(kind_t k);
    case (k)
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY: return CH_CLOSE_CURLY;
      KIND_ANGLE: return CH_CLOSE_ANGLE;
      default: return CH_CLOSE_PAREN;
    endcase
  endfunction

  function automatic char_t filler_char();
    char_t c;
    do c = char_t'($urandom_range(0, 255)); while (is_opener(c) || is_closer(c));
    return c;
  endfunction

  // Half brackets, half arbitrary bytes.
  function automatic char_t noisy_char();
    kind_t k;
    k = kind_t'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) return char_t'($urandom_range(0, 255));
    return ($urandom_range(0, 1) == 0) ? opener_of(k) : closer_of(k);
  endfunction

  // Advances the predictor by one character and returns the result it causes.
  function automatic result_t predict_bracket(char_t ch, logic last);
    result_t r;
    logic    is_gt;
    is_gt = (ch == CH_CLOSE_ANGLE);
    if (!string_failed) begin
      if (is_gt && prev_gt) begin
        string_failed = 1'b1;
      end else if (is_opener(ch)) begin
        if (nest_depth < DEPTH) begin
          nest_stack[nest_depth] = kind_of(ch);
          nest_depth++;
        end
      end else if (is_closer(ch)) begin
        if (nest_depth > 0 && nest_stack[nest_depth - 1] == kind_of(ch)) begin
          nest_depth--;
        end else begin
          string_failed = 1'b1;
        end
      end
    end
    prev_gt = is_gt;
    r.failed = string_failed;
    r.done = last;
    r.balanced = last && !string_failed && nest_depth == 0;
    if (last) begin
      nest_depth = 0;
      string_failed = 1'b0;
      prev_gt = 1'b0;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, result_t want, result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected failed=%b done=%b balanced=%b, got failed=%b done=%b balanced=%b",
               $realtime, what, want.failed, want.done, want.balanced,
               seen.failed, seen.done, seen.balanced);
    end
  endtask

  // Must be called right after a rising edge; returns right after the accepting edge.
  task automatic send_char(char_t ch, logic last);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    in_last_char <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_results.push_back(predict_bracket(ch, last));
    items_sent++;
  endtask

  task automatic send_draft();
    send_fast = ($urandom_range(0, 3) == 0);
    foreach (draft[i]) send_char(draft[i], i == draft.size() - 1);
  endtask

  // Appends a character, keeping a well-formed string free of adjacent '>' pairs.
  task automatic add_char(char_t ch);
    if (ch == CH_CLOSE_ANGLE && draft.size() > 0 && draft[$] == CH_CLOSE_ANGLE)
      draft.push_back(filler_char());
    draft.push_back(ch);
  endtask

  task automatic send_text(string s);
    draft.delete();
    for (int i = 0; i < s.len(); i++) draft.push_back(char_t'(s[i]));
    send_draft();
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_matched_strings();
    send_text("([{<>}])");
    draft = '{8'hFF};
    send_draft();
    // Leftover opener with only noise after it.
    draft = '{CH_OPEN_PAREN, 8'h00, 8'hFF};
    send_draft();
    pause_until_drained();
  endtask

  task automatic test_failing_strings();
    send_text("(]");
    send_text(")");
    send_text("<>>");
    // The stack must stay frozen once the string has failed.
    send_text("]()");
    pause_until_drained();
  endtask

  task automatic test_stack_overflow();
    kind_t kept[$];
    kind_t k;
    draft.delete();
    repeat (DEPTH + 2) begin
      k = kind_t'($urandom_range(0, 3));
      if (kept.size() < DEPTH) kept.push_back(k);
      draft.push_back(opener_of(k));
    end
    while (kept.size() > 0) add_char(closer_of(kept.pop_back()));
    send_draft();
    // Ends on an opener that is dropped because the stack is full.
    draft.delete();
    repeat (DEPTH + 1) draft.push_back(opener_of(kind_t'($urandom_range(0, 3))));
    send_draft();
    pause_until_drained();
  endtask

  task automatic random_string();
    kind_t open_q[$];
    int    flavor;
    int    steps;
    int    pos;
    kind_t k;
    draft.delete();
    flavor = $urandom_range(0, 9);
    steps = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
    if (flavor == 9) begin
      repeat (steps) draft.push_back(noisy_char());
    end else begin
      repeat (steps) begin
        case ($urandom_range(0, 4))
          0, 1: begin
            k = kind_t'($urandom_range(0, 3));
            open_q.push_back(k);
            add_char(opener_of(k));
          end
          2, 3: begin
            if (open_q.size() > 0) add_char(closer_of(open_q.pop_back()));
            else add_char(filler_char());
          end
          default: add_char(filler_char());
        endcase
      end
      // Flavor 8 leaves its openers unclosed.
      if (flavor != 8) while (open_q.size() > 0) add_char(closer_of(open_q.pop_back()));
      if (flavor == 7) begin
        pos = $urandom_range(0, draft.size() - 1);
        k = kind_t'($urandom_range(0, 3));
        draft[pos] = ($urandom_range(0, 1) == 0) ? opener_of(k) : closer_of(k);
      end
    end
    send_draft();
  endtask

  task automatic test_random_strings();
    int strings_done;
    strings_done = 0;
    while (items_sent < ITEM_TARGET) begin
      random_string();
      strings_done++;
      if (strings_done % 40 == 0) pause_until_drained();
    end
    pause_until_drained();
  endtask

  // Result side: a random stall before each item, with stall-free stretches.
  initial begin
    int stall;
    int fast_left;
    fast_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (fast_left > 0) begin
        stall = 0;
        fast_left--;
      end else begin
        if ($urandom_range(0, 7) == 0) fast_left = $urandom_range(10, 60);
        stall = $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
    end
  end

  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      seen.failed = out_failed_so_far;
      seen.done = out_string_done;
      seen.balanced = out_balanced;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, seen);
      end else begin
        want = expected_results.pop_front();
        if (seen.failed !== want.failed || seen.done !== want.done ||
            seen.balanced !== want.balanced)
          note_mismatch("result mismatch", want, seen);
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_in <= 8'h00;
    in_last_char <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_matched_strings();
    test_failing_strings();
    test_stack_overflow();
    test_random_strings();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      note_mismatch("result never arrived", expected_results[0], '0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bbc_pkg.sv
hdl/bbc_ram.sv
hdl/bbc_out_buf.sv
hdl/bracket_balance_checker_top.sv
test/tb_bracket_balance_checker_top.sv
